// File: src/bsaw_pkg.sv
package bsaw_pkg;

   // Field widths of the request and response payloads
   localparam int SIZE_BITS   = 16;
   localparam int STRIDE_BITS = 32;
   localparam int OFFSET_BITS = 48;

   // Request kinds
   localparam logic [2:0] KIND_LOAD_A   = 3'd0;
   localparam logic [2:0] KIND_LOAD_B   = 3'd1;
   localparam logic [2:0] KIND_LOAD_RES = 3'd2;
   localparam logic [2:0] KIND_START    = 3'd3;
   localparam logic [2:0] KIND_STEP     = 3'd4;

   // Response kinds
   localparam logic [1:0] RK_DIM     = 2'd0;
   localparam logic [1:0] RK_INCOMPAT = 2'd1;
   localparam logic [1:0] RK_OFFSETS = 2'd2;
   localparam logic [1:0] RK_REFUSED = 2'd3;

   // Operand selects for the delta table and running offsets
   localparam logic [1:0] OPND_A = 2'd0;
   localparam logic [1:0] OPND_B = 2'd1;
   localparam logic [1:0] OPND_R = 2'd2;

   typedef struct packed {
      logic [2:0]                    kind;
      logic [2:0]                    dim_index;
      logic [SIZE_BITS-1:0]          dim_size;
      logic signed [STRIDE_BITS-1:0] dim_stride;
      logic [3:0]                    rank_a;
      logic [3:0]                    rank_b;
   } req_type;

   typedef struct packed {
      logic [1:0]                    result_kind;
      logic [2:0]                    out_dim_index;
      logic [SIZE_BITS-1:0]          out_dim_size;
      logic signed [OFFSET_BITS-1:0] offset_a;
      logic signed [OFFSET_BITS-1:0] offset_b;
      logic signed [OFFSET_BITS-1:0] offset_r;
      logic                          last_report;
      logic                          walk_done;
   } rsp_type;

   typedef struct packed {
      logic mul_en;
      logic sub;
   } arith_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DSUB,
      ST_DACC,
      ST_REPORT,
      ST_STEP,
      ST_SADD,
      ST_REFUSE
   } state_type;

endpackage

// File: src/broadcast_stride_address_walker.sv
// Broadcast stride walker: load requests store per-dimension sizes and byte strides for
// operands A and B and result strides. A start request right-aligns the two shapes,
// checks them innermost first against the broadcast rule and then, through one shared
// 48-bit adder and one 16x32 multiplier, builds a table of per-dimension carry deltas in
// a memory with one write port and one read port before it reports each output extent;
// a failed dimension check ends the start with an incompatibility report. A step request
// returns the A, B and result byte offsets of the next element in row-major order and,
// unless the walk is done, then folds the carry delta of the advanced dimension into the
// three running offsets, one operand per cycle on the shared adder. The request channel
// is stalled while a start or step is in progress; results wait in an output register.
module broadcast_stride_address_walker #(
   parameter int MAX_RANK = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bsaw_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bsaw_pkg::rsp_type rsp_data
);

   localparam int SB       = bsaw_pkg::SIZE_BITS;
   localparam int TB       = bsaw_pkg::STRIDE_BITS;
   localparam int OB       = bsaw_pkg::OFFSET_BITS;
   localparam int IDX_W    = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
   localparam int RANK_W   = $clog2(MAX_RANK + 1);
   localparam int CD_DEPTH = 3 * MAX_RANK;
   localparam int CD_AW    = $clog2(CD_DEPTH);

   function automatic logic [RANK_W-1:0] clamp_rank(input logic [3:0] r);
      logic [RANK_W-1:0] res;
      if (r == 4'd0) begin
         res = RANK_W'(1);
      end else if (int'(r) > MAX_RANK) begin
         res = RANK_W'(MAX_RANK);
      end else begin
         res = RANK_W'(r);
      end
      return res;
   endfunction

   function automatic logic [CD_AW-1:0] cd_addr(input logic [1:0] op,
                                                input logic [IDX_W-1:0] d);
      return CD_AW'(op) * CD_AW'(MAX_RANK) + CD_AW'(d);
   endfunction

   // Loaded shape and stride tables
   logic [SB-1:0]        sizes_a_ff [MAX_RANK];
   logic [SB-1:0]        sizes_b_ff [MAX_RANK];
   logic signed [TB-1:0] strides_a_ff [MAX_RANK];
   logic signed [TB-1:0] strides_b_ff [MAX_RANK];
   logic signed [TB-1:0] strides_res_ff [MAX_RANK];

   // Broadcast results of the last start
   logic [SB-1:0]        out_sizes_ff [MAX_RANK];
   logic signed [TB-1:0] eff_a_ff [MAX_RANK];
   logic signed [TB-1:0] eff_b_ff [MAX_RANK];

   // Walk state
   logic [SB-1:0] cnt_ff [MAX_RANK];
   logic [OB-1:0] offs_ff [3];
   logic          walk_active_ff, walk_active_in;

   // Carry delta memory
   logic [OB-1:0]    cd_mem [CD_DEPTH];
   logic [OB-1:0]    cd_rdata_ff;
   logic [CD_AW-1:0] cd_waddr, cd_raddr;
   logic             cd_we;

   // Sequencer registers
   bsaw_pkg::state_type state_ff, state_in;
   logic [RANK_W-1:0]   ra_ff, ra_in, rb_ff, rb_in, rk_ff, rk_in;
   logic [IDX_W-1:0]    i_ff, i_in;
   logic [1:0]          op_ff, op_in;
   logic [OB-1:0]       acc_ff, acc_in;
   logic                any_zero_ff, any_zero_in;
   logic [IDX_W-1:0]    step_d_ff, step_d_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   bsaw_pkg::rsp_type rsp_ff, rsp_in;
   logic              load_out;
   logic              out_free;

   // Control strobes
   logic accept;
   logic load_a_we, load_b_we, load_r_we;
   logic chk_we;
   logic start_clear;
   logic cnt_step;
   logic off_we;

   // Check datapath
   logic              ha, hb;
   logic [RANK_W-1:0] a_pos, b_pos, o_pos;
   logic [IDX_W-1:0]  a_idx, b_idx, o_idx;
   logic [SB-1:0]     da, db, dout;
   logic              mismatch;
   logic              last_i;

   // Delta datapath
   logic signed [TB-1:0] stride_sel;
   logic [SB-1:0]        m_sel;
   logic [OB-1:0]        stride_ext;

   // Step search
   logic             found;
   logic [IDX_W-1:0] found_d;

   // Shared arithmetic unit
   bsaw_pkg::arith_ctl_type arith_ctl;
   logic [OB-1:0]           add_a, add_b, prod, sum;

   bsaw_arith u_arith (
      .clock      (clock),
      .ctl        (arith_ctl),
      .mul_size   (m_sel),
      .mul_stride (stride_sel),
      .add_a      (add_a),
      .add_b      (add_b),
      .prod       (prod),
      .sum        (sum)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != bsaw_pkg::ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Right-align the operand shapes for check index i
   always_comb begin
      ha    = (RANK_W'(i_ff) < ra_ff);
      hb    = (RANK_W'(i_ff) < rb_ff);
      a_pos = ra_ff - RANK_W'(1) - RANK_W'(i_ff);
      b_pos = rb_ff - RANK_W'(1) - RANK_W'(i_ff);
      o_pos = rk_ff - RANK_W'(1) - RANK_W'(i_ff);
      a_idx = ha ? a_pos[IDX_W-1:0] : '0;
      b_idx = hb ? b_pos[IDX_W-1:0] : '0;
      o_idx = o_pos[IDX_W-1:0];
      da    = ha ? sizes_a_ff[a_idx] : SB'(1);
      db    = hb ? sizes_b_ff[b_idx] : SB'(1);
      last_i = (RANK_W'(i_ff) == rk_ff - RANK_W'(1));
      mismatch = 1'b0;
      if (da == db || db == SB'(1)) begin
         dout = da;
      end else if (da == SB'(1)) begin
         dout = db;
      end else begin
         dout     = '0;
         mismatch = 1'b1;
      end
   end

   // Select stride and span factor for the delta pass
   always_comb begin
      unique case (op_ff)
         bsaw_pkg::OPND_A: stride_sel = eff_a_ff[i_ff];
         bsaw_pkg::OPND_B: stride_sel = eff_b_ff[i_ff];
         default:          stride_sel = strides_res_ff[i_ff];
      endcase
      stride_ext = {{(OB - TB){stride_sel[TB-1]}}, stride_sel};
      m_sel = (out_sizes_ff[i_ff] == '0) ? '0 : out_sizes_ff[i_ff] - SB'(1);
   end

   // Find the innermost dimension that can still advance
   always_comb begin
      found   = 1'b0;
      found_d = '0;
      for (int d = 0; d < MAX_RANK; d++) begin
         if (d < int'(rk_ff) &&
             ({1'b0, cnt_ff[d]} + (SB + 1)'(1)) < {1'b0, out_sizes_ff[d]}) begin
            found   = 1'b1;
            found_d = IDX_W'(d);
         end
      end
   end

   // Delta memory addresses
   assign cd_waddr = cd_addr(op_ff, i_ff);
   always_comb begin
      if (state_ff == bsaw_pkg::ST_STEP) begin
         cd_raddr = cd_addr(bsaw_pkg::OPND_A, found_d);
      end else if (state_ff == bsaw_pkg::ST_SADD && op_ff != bsaw_pkg::OPND_R) begin
         cd_raddr = cd_addr(2'(op_ff + 2'd1), step_d_ff);
      end else begin
         cd_raddr = '0;
      end
   end

   // Sequencer: next state and outputs
   always_comb begin
      state_in       = state_ff;
      ra_in          = ra_ff;
      rb_in          = rb_ff;
      rk_in          = rk_ff;
      i_in           = i_ff;
      op_in          = op_ff;
      acc_in         = acc_ff;
      any_zero_in    = any_zero_ff;
      step_d_in      = step_d_ff;
      walk_active_in = walk_active_ff;
      load_out       = 1'b0;
      rsp_in         = '0;
      load_a_we      = 1'b0;
      load_b_we      = 1'b0;
      load_r_we      = 1'b0;
      chk_we         = 1'b0;
      start_clear    = 1'b0;
      cnt_step       = 1'b0;
      off_we         = 1'b0;
      cd_we          = 1'b0;
      arith_ctl      = '0;
      add_a          = acc_ff;
      add_b          = prod;

      unique case (state_ff)
         bsaw_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_data.kind)
                  bsaw_pkg::KIND_LOAD_A: begin
                     load_a_we = (int'(req_data.dim_index) < MAX_RANK);
                  end
                  bsaw_pkg::KIND_LOAD_B: begin
                     load_b_we = (int'(req_data.dim_index) < MAX_RANK);
                  end
                  bsaw_pkg::KIND_LOAD_RES: begin
                     load_r_we = (int'(req_data.dim_index) < MAX_RANK);
                  end
                  bsaw_pkg::KIND_START: begin
                     ra_in          = clamp_rank(req_data.rank_a);
                     rb_in          = clamp_rank(req_data.rank_b);
                     rk_in          = (ra_in > rb_in) ? ra_in : rb_in;
                     i_in           = '0;
                     any_zero_in    = 1'b0;
                     walk_active_in = 1'b0;
                     start_clear    = 1'b1;
                     state_in       = bsaw_pkg::ST_CHECK;
                  end
                  bsaw_pkg::KIND_STEP: begin
                     state_in = walk_active_ff ? bsaw_pkg::ST_STEP : bsaw_pkg::ST_REFUSE;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Check one aligned dimension pair per cycle, innermost first
         bsaw_pkg::ST_CHECK: begin
            if (mismatch) begin
               if (out_free) begin
                  load_out                  = 1'b1;
                  rsp_in.result_kind        = bsaw_pkg::RK_INCOMPAT;
                  rsp_in.out_dim_index      = 3'(o_idx);
                  rsp_in.last_report        = 1'b1;
                  state_in                  = bsaw_pkg::ST_IDLE;
               end
            end else begin
               chk_we      = 1'b1;
               any_zero_in = any_zero_ff | (dout == '0);
               if (last_i) begin
                  op_in    = bsaw_pkg::OPND_A;
                  i_in     = IDX_W'(rk_ff - RANK_W'(1));
                  acc_in   = '0;
                  state_in = bsaw_pkg::ST_DSUB;
               end else begin
                  i_in = i_ff + IDX_W'(1);
               end
            end
         end

         // Delta = stride minus span of inner dims; start the span product
         bsaw_pkg::ST_DSUB: begin
            arith_ctl.sub    = 1'b1;
            arith_ctl.mul_en = 1'b1;
            add_a            = stride_ext;
            add_b            = acc_ff;
            cd_we            = 1'b1;
            state_in         = bsaw_pkg::ST_DACC;
         end

         // Accumulate the span, then move outward, to the next operand or to the report
         bsaw_pkg::ST_DACC: begin
            add_a    = acc_ff;
            add_b    = prod;
            acc_in   = sum;
            state_in = bsaw_pkg::ST_DSUB;
            if (i_ff == '0) begin
               if (op_ff == bsaw_pkg::OPND_R) begin
                  i_in     = '0;
                  state_in = bsaw_pkg::ST_REPORT;
               end else begin
                  op_in  = 2'(op_ff + 2'd1);
                  i_in   = IDX_W'(rk_ff - RANK_W'(1));
                  acc_in = '0;
               end
            end else begin
               i_in = i_ff - IDX_W'(1);
            end
         end

         // Report output extents outermost first
         bsaw_pkg::ST_REPORT: begin
            if (out_free) begin
               load_out             = 1'b1;
               rsp_in.result_kind   = bsaw_pkg::RK_DIM;
               rsp_in.out_dim_index = 3'(i_ff);
               rsp_in.out_dim_size  = out_sizes_ff[i_ff];
               rsp_in.last_report   = last_i;
               if (last_i) begin
                  walk_active_in = !any_zero_ff;
                  state_in       = bsaw_pkg::ST_IDLE;
               end else begin
                  i_in = i_ff + IDX_W'(1);
               end
            end
         end

         // Emit current offsets and advance the index counters
         bsaw_pkg::ST_STEP: begin
            if (out_free) begin
               load_out           = 1'b1;
               rsp_in.result_kind = bsaw_pkg::RK_OFFSETS;
               rsp_in.offset_a    = offs_ff[bsaw_pkg::OPND_A];
               rsp_in.offset_b    = offs_ff[bsaw_pkg::OPND_B];
               rsp_in.offset_r    = offs_ff[bsaw_pkg::OPND_R];
               rsp_in.last_report = 1'b1;
               rsp_in.walk_done   = !found;
               if (found) begin
                  cnt_step  = 1'b1;
                  step_d_in = found_d;
                  op_in     = bsaw_pkg::OPND_A;
                  state_in  = bsaw_pkg::ST_SADD;
               end else begin
                  walk_active_in = 1'b0;
                  state_in       = bsaw_pkg::ST_IDLE;
               end
            end
         end

         // Fold one operand's carry delta into its running offset
         bsaw_pkg::ST_SADD: begin
            add_a  = offs_ff[op_ff];
            add_b  = cd_rdata_ff;
            off_we = 1'b1;
            if (op_ff == bsaw_pkg::OPND_R) begin
               state_in = bsaw_pkg::ST_IDLE;
            end else begin
               op_in = 2'(op_ff + 2'd1);
            end
         end

         bsaw_pkg::ST_REFUSE: begin
            if (out_free) begin
               load_out           = 1'b1;
               rsp_in.result_kind = bsaw_pkg::RK_REFUSED;
               rsp_in.last_report = 1'b1;
               state_in           = bsaw_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = bsaw_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);

   // State register and control flops
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= bsaw_pkg::ST_IDLE;
         walk_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rk_ff          <= '0;
         ra_ff          <= '0;
         rb_ff          <= '0;
         i_ff           <= '0;
         op_ff          <= '0;
         any_zero_ff    <= 1'b0;
         step_d_ff      <= '0;
      end else begin
         state_ff       <= state_in;
         walk_active_ff <= walk_active_in;
         rsp_valid_ff   <= rsp_valid_in;
         rk_ff          <= rk_in;
         ra_ff          <= ra_in;
         rb_ff          <= rb_in;
         i_ff           <= i_in;
         op_ff          <= op_in;
         any_zero_ff    <= any_zero_in;
         step_d_ff      <= step_d_in;
      end
   end

   // Hold the span accumulator and the response payload
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   // Write loaded dimensions
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < MAX_RANK; d++) begin
            sizes_a_ff[d]     <= '0;
            sizes_b_ff[d]     <= '0;
            strides_a_ff[d]   <= '0;
            strides_b_ff[d]   <= '0;
            strides_res_ff[d] <= '0;
         end
      end else begin
         if (load_a_we) begin
            sizes_a_ff[IDX_W'(req_data.dim_index)]   <= req_data.dim_size;
            strides_a_ff[IDX_W'(req_data.dim_index)] <= req_data.dim_stride;
         end
         if (load_b_we) begin
            sizes_b_ff[IDX_W'(req_data.dim_index)]   <= req_data.dim_size;
            strides_b_ff[IDX_W'(req_data.dim_index)] <= req_data.dim_stride;
         end
         if (load_r_we) begin
            strides_res_ff[IDX_W'(req_data.dim_index)] <= req_data.dim_stride;
         end
      end
   end

   // Record broadcast extents and effective strides
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < MAX_RANK; d++) begin
            out_sizes_ff[d] <= '0;
            eff_a_ff[d]     <= '0;
            eff_b_ff[d]     <= '0;
         end
      end else if (chk_we) begin
         out_sizes_ff[o_idx] <= dout;
         eff_a_ff[o_idx]     <= (ha && da != SB'(1)) ? strides_a_ff[a_idx] : '0;
         eff_b_ff[o_idx]     <= (hb && db != SB'(1)) ? strides_b_ff[b_idx] : '0;
      end
   end

   // Advance index counters: bump the found dim, zero the inner ones
   always_ff @(posedge clock) begin
      if (reset || start_clear) begin
         for (int d = 0; d < MAX_RANK; d++) begin
            cnt_ff[d] <= '0;
         end
      end else if (cnt_step) begin
         for (int d = 0; d < MAX_RANK; d++) begin
            if (IDX_W'(d) == found_d) begin
               cnt_ff[d] <= cnt_ff[d] + SB'(1);
            end else if (IDX_W'(d) > found_d) begin
               cnt_ff[d] <= '0;
            end
         end
      end
   end

   // Running offsets
   always_ff @(posedge clock) begin
      if (start_clear) begin
         for (int k = 0; k < 3; k++) begin
            offs_ff[k] <= '0;
         end
      end else if (off_we) begin
         offs_ff[op_ff] <= sum;
      end
   end

   // Carry delta memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cd_we) begin
         cd_mem[cd_waddr] <= sum;
      end
      cd_rdata_ff <= cd_mem[cd_raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A pending response is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      load_out |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response register overwritten while stalled");

   // The final element of a walk ends the walk
   assert property (@(posedge clock) disable iff (reset)
      (load_out && rsp_in.result_kind == bsaw_pkg::RK_OFFSETS && rsp_in.walk_done)
      |=> !walk_active_ff)
      else $error("walk still active after its final element");

   // A step is refused only when no walk is active
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == bsaw_pkg::ST_REFUSE) |-> !walk_active_ff)
      else $error("step refused during an active walk");

endmodule

// File: src/bsaw_arith.sv
module bsaw_arith (
   input  logic                                    clock,
   input  bsaw_pkg::arith_ctl_type                 ctl,
   input  logic [bsaw_pkg::SIZE_BITS-1:0]          mul_size,
   input  logic signed [bsaw_pkg::STRIDE_BITS-1:0] mul_stride,
   input  logic [bsaw_pkg::OFFSET_BITS-1:0]        add_a,
   input  logic [bsaw_pkg::OFFSET_BITS-1:0]        add_b,
   output logic [bsaw_pkg::OFFSET_BITS-1:0]        prod,
   output logic [bsaw_pkg::OFFSET_BITS-1:0]        sum
);

   localparam int PW = bsaw_pkg::SIZE_BITS + bsaw_pkg::STRIDE_BITS + 1;

   logic signed [bsaw_pkg::SIZE_BITS:0] size_s;
   logic signed [PW-1:0]                prod_full;
   logic [bsaw_pkg::OFFSET_BITS-1:0]    prod_ff;
   logic [bsaw_pkg::OFFSET_BITS-1:0]    prod_in;
   logic [bsaw_pkg::OFFSET_BITS-1:0]    b_sel;

   // Multiply unsigned extent by signed stride, keep the low offset bits
   assign size_s    = $signed({1'b0, mul_size});
   assign prod_full = PW'(size_s) * PW'(mul_stride);
   assign prod_in   = prod_full[bsaw_pkg::OFFSET_BITS-1:0];

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

   // Shared add / subtract, wrapping at the offset width
   assign b_sel = ctl.sub ? ~add_b : add_b;
   assign sum   = add_a + b_sel + bsaw_pkg::OFFSET_BITS'(ctl.sub);

endmodule

// File: dv/broadcast_stride_address_walker_tb.sv
`timescale 1ns / 100ps

module broadcast_stride_address_walker_tb;
   import bsaw_pkg::*;

   localparam int WALK_RANK      = 8;
   localparam int RANDOM_ITEMS   = 360;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 100;
   localparam int MAX_SHOWN      = 10;

   // Request kinds the block ignores
   localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
   localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

   typedef struct packed {
      req_type rq;
      logic    typed;
      rsp_type want;
   } dir_row_t;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // Walker state as predicted
   logic [15:0] mdl_size_a[WALK_RANK];
   logic [15:0] mdl_size_b[WALK_RANK];
   logic [31:0] mdl_stride_a[WALK_RANK];
   logic [31:0] mdl_stride_b[WALK_RANK];
   logic [31:0] mdl_stride_r[WALK_RANK];
   logic [15:0] mdl_out_size[WALK_RANK];
   logic [47:0] mdl_delta[3][WALK_RANK];
   logic [15:0] mdl_index[WALK_RANK];
   logic [47:0] mdl_pos[3];
   int          mdl_rank;
   bit          mdl_walking;

   rsp_type  awaited_reports[$];
   dir_row_t dir_rows[$];
   int       fail_count;
   int       items_sent;
   int       rsp_seen;
   int       idle_cycles;
   int       hold_left;
   bit       quiet_mode;

   broadcast_stride_address_walker u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_SHOWN) $display("ERROR: %s", msg);
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic logic [47:0] widen_stride(input logic [31:0] s);
      return {{16{s[31]}}, s};
   endfunction

   function automatic req_type make_req(input logic [2:0] k, input logic [2:0] idx,
                                        input logic [15:0] sz, input logic [31:0] st,
                                        input logic [3:0] ra, input logic [3:0] rb);
      req_type rq;
      rq.kind       = k;
      rq.dim_index  = idx;
      rq.dim_size   = sz;
      rq.dim_stride = st;
      rq.rank_a     = ra;
      rq.rank_b     = rb;
      return rq;
   endfunction

   function automatic rsp_type make_rsp(input logic [1:0] k, input logic [2:0] idx,
                                        input logic [15:0] sz, input logic [47:0] oa,
                                        input logic [47:0] ob, input logic [47:0] orr,
                                        input logic last, input logic done);
      rsp_type rs;
      rs.result_kind   = k;
      rs.out_dim_index = idx;
      rs.out_dim_size  = sz;
      rs.offset_a      = oa;
      rs.offset_b      = ob;
      rs.offset_r      = orr;
      rs.last_report   = last;
      rs.walk_done     = done;
      return rs;
   endfunction

   // Apply one request to the predicted walker; queue its responses when keep is set
   function automatic void advance_walker_model(input req_type rq, input bit keep);
      int          ra, rb, rk, i, o, d, e;
      bit          ha, hb, any_zero, advanced;
      logic [15:0] da, db, dout;
      logic [47:0] sa[WALK_RANK];
      logic [47:0] sb[WALK_RANK];
      logic [47:0] sr[WALK_RANK];
      logic [47:0] ia, ib, ir, span, pa, pb, pr;
      case (rq.kind)
         KIND_LOAD_A: begin
            mdl_size_a[rq.dim_index]   = rq.dim_size;
            mdl_stride_a[rq.dim_index] = rq.dim_stride;
         end
         KIND_LOAD_B: begin
            mdl_size_b[rq.dim_index]   = rq.dim_size;
            mdl_stride_b[rq.dim_index] = rq.dim_stride;
         end
         KIND_LOAD_RES: begin
            mdl_stride_r[rq.dim_index] = rq.dim_stride;
         end
         KIND_START: begin
            ra = (rq.rank_a == 0) ? 1 : ((rq.rank_a > WALK_RANK) ? WALK_RANK : rq.rank_a);
            rb = (rq.rank_b == 0) ? 1 : ((rq.rank_b > WALK_RANK) ? WALK_RANK : rq.rank_b);
            rk = (ra > rb) ? ra : rb;
            any_zero = 1'b0;
            mdl_walking = 1'b0;
            // Check the right-aligned shapes, innermost first
            for (i = 0; i < rk; i++) begin
               o  = rk - 1 - i;
               ha = (i < ra);
               hb = (i < rb);
               da = ha ? mdl_size_a[ra - 1 - i] : 16'd1;
               db = hb ? mdl_size_b[rb - 1 - i] : 16'd1;
               if (da == db || db == 16'd1) begin
                  dout = da;
               end else if (da == 16'd1) begin
                  dout = db;
               end else begin
                  if (keep) awaited_reports.push_back(make_rsp(RK_INCOMPAT, o, '0, '0, '0,
                                                               '0, 1'b1, 1'b0));
                  return;
               end
               mdl_out_size[o] = dout;
               sa[o] = (ha && da != 16'd1) ? widen_stride(mdl_stride_a[ra - 1 - i]) : '0;
               sb[o] = (hb && db != 16'd1) ? widen_stride(mdl_stride_b[rb - 1 - i]) : '0;
               sr[o] = widen_stride(mdl_stride_r[o]);
               if (dout == 16'd0) any_zero = 1'b1;
            end
            mdl_rank = rk;
            // Carry delta: stride of the dimension minus the span of all inner ones
            ia = '0;
            ib = '0;
            ir = '0;
            for (i = rk - 1; i >= 0; i--) begin
               span = (mdl_out_size[i] != 16'd0) ? mdl_out_size[i] - 1 : '0;
               mdl_delta[0][i] = sa[i] - ia;
               mdl_delta[1][i] = sb[i] - ib;
               mdl_delta[2][i] = sr[i] - ir;
               ia = ia + span * sa[i];
               ib = ib + span * sb[i];
               ir = ir + span * sr[i];
            end
            for (i = 0; i < WALK_RANK; i++) mdl_index[i] = '0;
            for (i = 0; i < 3; i++) mdl_pos[i] = '0;
            mdl_walking = !any_zero;
            for (i = 0; i < rk; i++) begin
               if (keep) awaited_reports.push_back(make_rsp(RK_DIM, i, mdl_out_size[i], '0,
                                                            '0, '0, i == rk - 1, 1'b0));
            end
         end
         KIND_STEP: begin
            if (!mdl_walking) begin
               if (keep) awaited_reports.push_back(make_rsp(RK_REFUSED, '0, '0, '0, '0, '0,
                                                            1'b1, 1'b0));
               return;
            end
            pa = mdl_pos[0];
            pb = mdl_pos[1];
            pr = mdl_pos[2];
            advanced = 1'b0;
            // Advance the innermost dimension that still has room
            for (d = mdl_rank - 1; d >= 0; d--) begin
               if (int'(mdl_index[d]) + 1 < int'(mdl_out_size[d])) begin
                  mdl_index[d] = mdl_index[d] + 1;
                  for (e = d + 1; e < mdl_rank; e++) mdl_index[e] = '0;
                  mdl_pos[0] = mdl_pos[0] + mdl_delta[0][d];
                  mdl_pos[1] = mdl_pos[1] + mdl_delta[1][d];
                  mdl_pos[2] = mdl_pos[2] + mdl_delta[2][d];
                  advanced = 1'b1;
                  break;
               end
            end
            if (!advanced) mdl_walking = 1'b0;
            if (keep) awaited_reports.push_back(make_rsp(RK_OFFSETS, '0, '0, pa, pb, pr,
                                                         1'b1, !advanced));
         end
         default: ;
      endcase
   endfunction

   // Present one request, hold it until accepted, then record what it should produce
   task automatic send_request(input req_type rq, input logic typed = 1'b0,
                               input rsp_type want = '0);
      int gap;
      gap = quiet_mode ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= rq;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (typed) begin
         advance_walker_model(rq, 1'b0);
         awaited_reports.push_back(want);
      end else begin
         advance_walker_model(rq, 1'b1);
      end
      if (rq.kind <= KIND_STEP) items_sent++;
      @(negedge clock);
   endtask

   // Hold off new requests until every response has come back
   task automatic drain_pause();
      req_valid <= 1'b0;
      while (awaited_reports.size() != 0) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_stride();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 32'($urandom_range(0, 32)) - 32'd16;
      if (r < 75) return 32'($urandom_range(1, 65536));
      if (r < 85) return 32'd0 - 32'($urandom_range(1, 65536));
      return $urandom;
   endfunction

   function automatic int pick_rank();
      if ($urandom_range(0, 9) < 7) return $urandom_range(1, 3);
      return $urandom_range(1, WALK_RANK);
   endfunction

   task automatic send_noise();
      send_request(make_req($urandom_range(0, 7), $urandom_range(0, 7),
                            $urandom_range(0, 65535), $urandom,
                            $urandom_range(0, 15), $urandom_range(0, 15)));
   endtask

   // Load a broadcast-compatible (sometimes broken) shape pair, start it, then walk
   task automatic run_walk_sequence();
      int          ra, rb, rk, o, j, r, s, total, n_steps, lo;
      logic [15:0] out_sz[WALK_RANK];
      logic [15:0] sz_a[WALK_RANK];
      logic [15:0] sz_b[WALK_RANK];
      logic [3:0]  ra_field, rb_field;
      bit          big, broken;
      ra = pick_rank();
      rb = pick_rank();
      rk = (ra > rb) ? ra : rb;
      r = $urandom_range(0, 99);
      big = (r < 6);
      broken = (r >= 6 && r < 20);
      total = 1;
      for (o = 0; o < rk; o++) begin
         s = big ? 1 : $urandom_range(1, 4);
         if (total * s > 30) s = 1;
         out_sz[o] = s;
         total = total * s;
      end
      if (big) begin
         o = $urandom_range(0, rk - 1);
         out_sz[o] = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(2, 65535));
         total = out_sz[o];
      end
      if (r >= 94) begin
         out_sz[$urandom_range(0, rk - 1)] = '0;
         total = 0;
      end
      // Split each output extent between the operands, broadcasting at random
      for (o = 0; o < rk; o++) begin
         sz_a[o] = out_sz[o];
         sz_b[o] = out_sz[o];
         s = $urandom_range(0, 3);
         if (o >= rk - ra && o >= rk - rb) begin
            if (s == 0) sz_a[o] = 16'd1;
            if (s == 1) sz_b[o] = 16'd1;
         end
      end
      if (broken) begin
         lo = rk - ((ra < rb) ? ra : rb);
         o = $urandom_range(lo, rk - 1);
         sz_b[o] = (out_sz[o] < 2) ? 16'd2 : out_sz[o];
         sz_a[o] = sz_b[o] + 1;
      end
      for (j = 0; j < ra; j++)
         send_request(make_req(KIND_LOAD_A, j, sz_a[rk - ra + j], pick_stride(),
                               $urandom_range(0, 15), $urandom_range(0, 15)));
      for (j = 0; j < rb; j++)
         send_request(make_req(KIND_LOAD_B, j, sz_b[rk - rb + j], pick_stride(),
                               $urandom_range(0, 15), $urandom_range(0, 15)));
      for (o = 0; o < rk; o++)
         send_request(make_req(KIND_LOAD_RES, o, $urandom_range(0, 65535), pick_stride(),
                               $urandom_range(0, 15), $urandom_range(0, 15)));
      ra_field = ra;
      rb_field = rb;
      if (ra == 1 && $urandom_range(0, 1)) ra_field = '0;
      if (rb == 1 && $urandom_range(0, 1)) rb_field = '0;
      if (ra == WALK_RANK && $urandom_range(0, 1)) ra_field = $urandom_range(9, 15);
      if (rb == WALK_RANK && $urandom_range(0, 1)) rb_field = $urandom_range(9, 15);
      send_request(make_req(KIND_START, $urandom_range(0, 7), $urandom_range(0, 65535),
                            $urandom, ra_field, rb_field));
      if (broken) n_steps = $urandom_range(0, 2);
      else if (total == 0) n_steps = 1;
      else if (total <= 40 && $urandom_range(0, 3) != 0) n_steps = total + 1;
      else n_steps = $urandom_range(1, (total < 40) ? total : 40);
      repeat (n_steps)
         send_request(make_req(KIND_STEP, $urandom_range(0, 7), $urandom_range(0, 65535),
                               $urandom, $urandom_range(0, 15), $urandom_range(0, 15)));
   endtask

   // Random response back-pressure, with quiet stretches
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (!quiet_mode && hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (!quiet_mode && $urandom_range(0, 3) == 0) hold_left = idle_len();
      end
   end

   // Compare each response with the oldest outstanding expectation
   always @(posedge clock) begin : check_responses
      rsp_type want;
      string   diffs;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_reports.size() == 0) begin
            note_failure($sformatf("response %0d not expected: %h", rsp_seen, rsp_data));
         end else begin
            want = awaited_reports.pop_front();
            diffs = "";
            if (rsp_data.result_kind !== want.result_kind) diffs = {diffs, " result_kind"};
            if (rsp_data.out_dim_index !== want.out_dim_index) diffs = {diffs, " dim_index"};
            if (rsp_data.out_dim_size !== want.out_dim_size) diffs = {diffs, " dim_size"};
            if (rsp_data.offset_a !== want.offset_a) diffs = {diffs, " offset_a"};
            if (rsp_data.offset_b !== want.offset_b) diffs = {diffs, " offset_b"};
            if (rsp_data.offset_r !== want.offset_r) diffs = {diffs, " offset_r"};
            if (rsp_data.last_report !== want.last_report) diffs = {diffs, " last_report"};
            if (rsp_data.walk_done !== want.walk_done) diffs = {diffs, " walk_done"};
            if (diffs != "")
               note_failure($sformatf("response %0d differs in%s: expected %h got %h",
                                      rsp_seen, diffs, want, rsp_data));
         end
         rsp_seen++;
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", idle_cycles);
         $display("broadcast_stride_address_walker regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int i;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_stall   = 1'b0;
      quiet_mode  = 1'b0;
      hold_left   = 0;
      fail_count  = 0;
      items_sent  = 0;
      rsp_seen    = 0;
      idle_cycles = 0;
      mdl_rank    = 0;
      mdl_walking = 1'b0;
      for (i = 0; i < WALK_RANK; i++) begin
         mdl_size_a[i]   = '0;
         mdl_size_b[i]   = '0;
         mdl_stride_a[i] = '0;
         mdl_stride_b[i] = '0;
         mdl_stride_r[i] = '0;
         mdl_out_size[i] = '0;
         mdl_index[i]    = '0;
         mdl_delta[0][i] = '0;
         mdl_delta[1][i] = '0;
         mdl_delta[2][i] = '0;
      end
      for (i = 0; i < 3; i++) mdl_pos[i] = '0;

      // Directed table: step before any walk, empty shape, extreme strides, errors
      dir_rows.push_back(dir_row_t'{make_req(KIND_STEP, 0, 0, 0, 0, 0), 1'b1,
                         make_rsp(RK_REFUSED, 0, 0, 0, 0, 0, 1'b1, 1'b0)});
      dir_rows.push_back(dir_row_t'{make_req(KIND_START, 0, 0, 0, 0, 0), 1'b1,
                         make_rsp(RK_DIM, 0, 0, 0, 0, 0, 1'b1, 1'b0)});
      dir_rows.push_back(dir_row_t'{make_req(KIND_STEP, 0, 0, 0, 0, 0), 1'b1,
                         make_rsp(RK_REFUSED, 0, 0, 0, 0, 0, 1'b1, 1'b0)});
      dir_rows.push_back(dir_row_t'{make_req(KIND_UNUSED_LO, 7, 16'hFFFF, 32'hFFFF_FFFF,
                                             4'hF, 4'hF), 1'b0, '0});
      dir_rows.push_back(dir_row_t'{make_req(KIND_LOAD_A, 0, 2, 32'h7FFF_FFFF, 0, 0),
                                    1'b0, '0});
      dir_rows.push_back(dir_row_t'{make_req(KIND_LOAD_A, 1, 3, 32'h8000_0000, 0, 0),
                                    1'b0, '0});
      dir_rows.push_back(dir_row_t'{make_req(KIND_LOAD_B, 0, 3, 4, 0, 0), 1'b0, '0});
      dir_rows.push_back(dir_row_t'{make_req(KIND_LOAD_RES, 0, 0, 12, 0, 0), 1'b0, '0});
      dir_rows.push_back(dir_row_t'{make_req(KIND_LOAD_RES, 1, 0, 32'hFFFF_FFFC, 0, 0),
                                    1'b0, '0});
      dir_rows.push_back(dir_row_t'{make_req(KIND_START, 0, 0, 0, 2, 1), 1'b0, '0});
      for (i = 0; i < 7; i++)
         dir_rows.push_back(dir_row_t'{make_req(KIND_STEP, 0, 0, 0, 0, 0), 1'b0, '0});
      dir_rows.push_back(dir_row_t'{make_req(KIND_START, 0, 0, 0, 2, 2), 1'b1,
                         make_rsp(RK_INCOMPAT, 1, 0, 0, 0, 0, 1'b1, 1'b0)});
      dir_rows.push_back(dir_row_t'{make_req(KIND_LOAD_A, 7, 16'hFFFF, 32'hFFFF_FFFF, 0, 0),
                                    1'b0, '0});
      dir_rows.push_back(dir_row_t'{make_req(KIND_UNUSED_HI, 0, 0, 0, 0, 0), 1'b0, '0});
      dir_rows.push_back(dir_row_t'{make_req(KIND_START, 0, 0, 0, 15, 1), 1'b1,
                         make_rsp(RK_INCOMPAT, 7, 0, 0, 0, 0, 1'b1, 1'b0)});
      dir_rows.push_back(dir_row_t'{make_req(KIND_START, 0, 0, 0, 2, 1), 1'b0, '0});
      dir_rows.push_back(dir_row_t'{make_req(KIND_STEP, 0, 0, 0, 0, 0), 1'b0, '0});
      dir_rows.push_back(dir_row_t'{make_req(KIND_STEP, 0, 0, 0, 0, 0), 1'b0, '0});
      // Restart in the middle of a walk
      dir_rows.push_back(dir_row_t'{make_req(KIND_START, 0, 0, 0, 2, 1), 1'b0, '0});
      dir_rows.push_back(dir_row_t'{make_req(KIND_STEP, 0, 0, 0, 0, 0), 1'b0, '0});

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[k]) send_request(dir_rows[k].rq, dir_rows[k].typed, dir_rows[k].want);
      drain_pause();

      // Random part: mostly well-formed walks, some noise and broken shapes
      while (items_sent < dir_rows.size() + RANDOM_ITEMS) begin
         quiet_mode = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 4)) send_noise();
         run_walk_sequence();
         if ($urandom_range(0, 7) == 0) drain_pause();
      end
      req_valid <= 1'b0;
      quiet_mode = 1'b0;

      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_reports.size() != 0)
         note_failure($sformatf("%0d responses never arrived", awaited_reports.size()));
      if (fail_count == 0) begin
         $display("broadcast_stride_address_walker regression: pass");
      end else begin
         $display("broadcast_stride_address_walker regression: fail");
      end
      $finish;
   end

endmodule
